/* sv/fsk4_slicer_sync_voice_framer_defines.svh */
// Assertion macros used by the framer back end.
`ifndef FSK4_SLICER_SYNC_VOICE_FRAMER_DEFINES_SVH
`define FSK4_SLICER_SYNC_VOICE_FRAMER_DEFINES_SVH

// Same-cycle implication, checked on clk, masked during reset.
`define FSVF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, masked during reset.
`define FSVF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/fsvf_pkg.sv */
// Types and constants of the 4FSK slicer, sync detector and voice framer.
`default_nettype none

package fsvf_pkg;

	typedef enum logic [1:0] {
		CMD_SAMPLE    = 2'd0,
		CMD_TICK      = 2'd1,
		CMD_VOICE_RST = 2'd2,
		CMD_LOST_CARR = 2'd3
	} fsvf_cmd_t;

	typedef enum logic [1:0] {
		SYNC_NONE  = 2'd0,
		SYNC_DATA  = 2'd1,
		SYNC_VOICE = 2'd2
	} fsvf_sync_t;

	typedef enum logic [1:0] {
		DIBIT_P1 = 2'd0,
		DIBIT_P3 = 2'd1,
		DIBIT_M1 = 2'd2,
		DIBIT_M3 = 2'd3
	} fsvf_dibit_t;

	typedef enum logic [3:0] {
		PH_FIRST = 4'b0001,
		PH_MID_A = 4'b0010,
		PH_MID_B = 4'b0100,
		PH_LAST  = 4'b1000
	} fsvf_phase_t;

	typedef struct packed {
		fsvf_cmd_t cmd;
		logic [1:0] dibit;
	} fsvf_entry_t;

	typedef struct packed {
		logic       hold_expired;
		logic       lost_sync;
		logic       synced;
		logic [1:0] sync_kind;
		logic       frame_done;
		logic [5:0] voice_index;
		logic       voice_valid;
		logic [1:0] dibit;
	} fsvf_result_t;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [4:0] ADDR_LEVEL_MAX  = 5'd0;
	localparam logic [4:0] ADDR_DATA_SYNC  = 5'd8;
	localparam logic [4:0] ADDR_VOICE_SYNC = 5'd16;

	localparam logic [14:0] LEVEL_MAX_RST  = 15'd4096;
	localparam logic [47:0] DATA_SYNC_RST  = 48'd246368513220445;
	localparam logic [47:0] VOICE_SYNC_RST = 48'd128931274782199;

	localparam logic [16:0] SAMPLE_OFFSET   = 17'd256;
	localparam logic [5:0]  FRAME_LEN       = 6'd36;
	localparam logic [5:0]  HALF_FRAME      = 6'd18;
	localparam logic [7:0]  SYNC_SKIP       = 8'd24;
	localparam logic [7:0]  CACH_SLOT_SKIP  = 8'd156;
	localparam logic [7:0]  DATA_SYNC_SKIP  = 8'd120;
	localparam logic [7:0]  VOICE_SYNC_SKIP = 8'd18;
	localparam logic [10:0] SYNC_HOLD_LOAD  = 11'd1738;
	localparam logic [10:0] SYNC_CONT_AT    = 11'd24;
	localparam logic [5:0]  TICK_HOLD_SYNC  = 6'd40;
	localparam logic [5:0]  TICK_HOLD_LOST  = 6'd25;
	localparam logic [2:0]  FRAMES_LOAD     = 3'd6;

endpackage

`default_nettype wire

/* sv/fsvf_front.sv */
// Front end: takes input beats and slices samples into dibits.
`default_nettype none

module fsvf_front (
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [15:0]          s_tdata,  // [15:0] sample
	input  wire logic [1:0]           s_tuser,  // [1:0] cmd
	input  wire logic [14:0]          level_max,
	input  wire logic                 q_ready,
	output logic                      q_push,
	output fsvf_pkg::fsvf_entry_t     q_entry
);
	import fsvf_pkg::*;

	logic signed [17:0] sum;
	logic signed [17:0] thr;
	logic signed [17:0] neg_thr;
	logic [1:0]         dibit;

	assign sum     = $signed({s_tdata[15], s_tdata[15], s_tdata}) +
	                 $signed({1'b0, SAMPLE_OFFSET});
	assign thr     = $signed({4'd0, level_max[14:1]});
	assign neg_thr = -thr;

	always_comb begin
		priority if (sum > thr) begin
			dibit = DIBIT_P3;
		end else if (sum > 18'sd0) begin
			dibit = DIBIT_P1;
		end else if (sum < neg_thr) begin
			dibit = DIBIT_M3;
		end else begin
			dibit = DIBIT_M1;
		end
	end

	assign s_tready      = q_ready;
	assign q_push        = s_tvalid & q_ready;
	assign q_entry.cmd   = fsvf_cmd_t'(s_tuser);
	assign q_entry.dibit = (fsvf_cmd_t'(s_tuser) == CMD_SAMPLE) ? dibit : 2'd0;

endmodule

`default_nettype wire

/* sv/fsvf_queue.sv */
// Short queue between the slicer front end and the framer back end.
`default_nettype none

module fsvf_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire fsvf_pkg::fsvf_entry_t push_entry,
	output logic                      push_ready,
	input  wire logic                 pop,
	output logic                      pop_valid,
	output fsvf_pkg::fsvf_entry_t     pop_entry
);
	import fsvf_pkg::*;

	fsvf_entry_t      mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != QDEPTH[QAW:0]);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/fsvf_back.sv */
// Back end: sync matching, voice burst phase machine, hold timers, result register.
`default_nettype none
`include "fsk4_slicer_sync_voice_framer_defines.svh"

module fsvf_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire fsvf_pkg::fsvf_entry_t q_entry,
	output logic                       q_pop,
	input  wire logic [47:0]           data_sync_word,
	input  wire logic [47:0]           voice_sync_word,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output fsvf_pkg::fsvf_result_t     out_res
);
	import fsvf_pkg::*;

	logic [47:0]  hist_q, hist_n;
	logic [7:0]   skip_q, skip_n;
	fsvf_phase_t  phase_q, phase_n;
	logic [5:0]   pos_q, pos_n;
	logic [2:0]   frames_q, frames_n;
	logic [10:0]  hold_q, hold_ld, hold_n;
	logic [5:0]   tick_q, tick_n;
	fsvf_result_t res;
	fsvf_result_t res_q;
	logic         vld_q;

	assign q_pop     = q_valid & (!vld_q | out_ready);
	assign out_valid = vld_q;
	assign out_res   = res_q;

	always_comb begin
		hist_n   = hist_q;
		skip_n   = skip_q;
		phase_n  = phase_q;
		pos_n    = pos_q;
		frames_n = frames_q;
		hold_ld  = hold_q;
		hold_n   = hold_q;
		tick_n   = tick_q;
		res      = '0;
		unique case (q_entry.cmd)
			CMD_SAMPLE: begin
				res.dibit = q_entry.dibit;
				hist_n    = {hist_q[45:0], q_entry.dibit};
				if (skip_q != 8'd0) begin
					skip_n = skip_q - 8'd1;
				end else if (hold_q != 11'd0) begin
					res.voice_valid = 1'b1;
					res.voice_index = pos_q;
					pos_n           = pos_q + 6'd1;
					unique case (phase_q)
						PH_FIRST: begin
							if (pos_n == FRAME_LEN) begin
								phase_n        = PH_MID_A;
								pos_n          = 6'd0;
								res.frame_done = 1'b1;
							end
						end
						PH_MID_A: begin
							if (pos_n == HALF_FRAME) begin
								phase_n = PH_MID_B;
								skip_n  = SYNC_SKIP;
							end
						end
						PH_MID_B: begin
							if (pos_n == FRAME_LEN) begin
								phase_n        = PH_LAST;
								pos_n          = 6'd0;
								res.frame_done = 1'b1;
							end
						end
						PH_LAST: begin
							if (pos_n == FRAME_LEN) begin
								res.frame_done = 1'b1;
								pos_n          = 6'd0;
								skip_n         = CACH_SLOT_SKIP;
								phase_n        = PH_FIRST;
								if (frames_q != 3'd0) begin
									frames_n = frames_q - 3'd1;
								end
							end
						end
						default: ;
					endcase
				end
				if (hist_n == data_sync_word) begin
					res.sync_kind = SYNC_DATA;
					if (hold_q == 11'd0) begin
						skip_n = DATA_SYNC_SKIP;
					end
				end else if (hist_n == voice_sync_word) begin
					res.sync_kind = SYNC_VOICE;
					if (frames_n == 3'd0 && hold_q == SYNC_CONT_AT) begin
						hold_ld  = SYNC_HOLD_LOAD;
						tick_n   = TICK_HOLD_SYNC;
						frames_n = FRAMES_LOAD;
					end else begin
						skip_n   = VOICE_SYNC_SKIP;
						phase_n  = PH_LAST;
						pos_n    = 6'd0;
						frames_n = FRAMES_LOAD;
						hold_ld  = SYNC_HOLD_LOAD;
						tick_n   = TICK_HOLD_SYNC;
					end
				end
				hold_n = hold_ld;
				if (hold_ld != 11'd0) begin
					hold_n = hold_ld - 11'd1;
					if (hold_n == 11'd0) begin
						res.lost_sync = 1'b1;
						tick_n        = TICK_HOLD_LOST;
						phase_n       = PH_FIRST;
					end
				end
			end
			CMD_TICK: begin
				if (tick_q != 6'd0) begin
					tick_n = tick_q - 6'd1;
					if (tick_n == 6'd0) begin
						res.hold_expired = 1'b1;
					end
				end
			end
			CMD_VOICE_RST: begin
				phase_n  = PH_FIRST;
				hold_n   = 11'd0;
				frames_n = 3'd0;
			end
			CMD_LOST_CARR: begin
				hold_n  = 11'd0;
				phase_n = PH_FIRST;
			end
			default: ;
		endcase
		res.synced = (hold_n != 11'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q   <= '0;
			skip_q   <= '0;
			phase_q  <= PH_FIRST;
			pos_q    <= '0;
			frames_q <= '0;
			hold_q   <= '0;
			tick_q   <= '0;
			vld_q    <= 1'b0;
		end else begin
			if (q_pop) begin
				hist_q   <= hist_n;
				skip_q   <= skip_n;
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				frames_q <= frames_n;
				hold_q   <= hold_n;
				tick_q   <= tick_n;
				vld_q    <= 1'b1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res;
		end
	end

	`FSVF_ASSERT_IMP(a_done_is_stored, vld_q && res_q.frame_done, res_q.voice_valid, "frame end without stored dibit")
	`FSVF_ASSERT_IMP(a_lost_not_synced, vld_q && res_q.lost_sync, !res_q.synced, "lost sync while still synced")
	`FSVF_ASSERT_IMP(a_expire_quiet, vld_q && res_q.hold_expired, !res_q.voice_valid && res_q.sync_kind == SYNC_NONE, "hold expiry on a sample beat")
	`FSVF_ASSERT_NXT(a_stall_holds, vld_q && !out_ready, vld_q && $stable(res_q), "result changed while stalled")

endmodule

`default_nettype wire

/* sv/fsk4_slicer_sync_voice_framer.sv */
// Top level of the 4FSK slicer, sync detector and voice burst framer.
// Input stream: one beat per command; s_tuser carries the command (sample, 100 ms tick,
// voice reset, lost carrier), s_tdata the signed symbol sample used by sample commands.
// Every input beat yields exactly one output beat: the sliced dibit with its voice frame
// position in m_tdata, frame end on m_tlast, and sync and timer flags in m_tuser.
// An input beat that is taken is written into the queue, and the framer result
// register then loads its result, which m_tvalid shows.
// Throughput: one beat per cycle while the output side does not stall.
// If the output side stalls, the result register holds and the four-entry queue keeps
// taking input beats until it fills, then s_tready drops.
// Reset clears the sync history, counters, phase machine and queue, and loads the
// configuration registers with their defaults; no clearing pass is needed.
// The APB port writes level_max at 0x00, the data sync word at 0x08 and the voice sync
// word at 0x10; write it only while no beats are in flight.
`default_nettype none

module fsk4_slicer_sync_voice_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [15:0] sample
	input  wire logic [1:0]  s_tuser,  // [1:0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [1:0] dibit, [7:2] voice_index
	output logic [5:0]       m_tuser,  // [0] voice_valid, [2:1] sync_kind, [3] synced,
	                                   // [4] lost_sync, [5] hold_expired
	output logic             m_tlast,  // frame_done
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import fsvf_pkg::*;

	logic [14:0]  level_max_q;
	logic [47:0]  data_sync_q;
	logic [47:0]  voice_sync_q;
	logic         cfg_wr;
	logic         q_ready;
	logic         q_push;
	fsvf_entry_t  q_in;
	logic         q_valid;
	logic         q_pop;
	fsvf_entry_t  q_out;
	fsvf_result_t res;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_max_q  <= LEVEL_MAX_RST;
			data_sync_q  <= DATA_SYNC_RST;
			voice_sync_q <= VOICE_SYNC_RST;
		end else if (cfg_wr) begin
			unique case (paddr)
				ADDR_LEVEL_MAX:  level_max_q  <= pwdata[14:0];
				ADDR_DATA_SYNC:  data_sync_q  <= pwdata[47:0];
				ADDR_VOICE_SYNC: voice_sync_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_LEVEL_MAX:  prdata = {49'd0, level_max_q};
			ADDR_DATA_SYNC:  prdata = {16'd0, data_sync_q};
			ADDR_VOICE_SYNC: prdata = {16'd0, voice_sync_q};
			default:         prdata = 64'd0;
		endcase
	end

	fsvf_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.level_max (level_max_q),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	fsvf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_out)
	);

	fsvf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_entry         (q_out),
		.q_pop           (q_pop),
		.data_sync_word  (data_sync_q),
		.voice_sync_word (voice_sync_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_res         (res)
	);

	assign m_tdata = {res.voice_index, res.dibit};
	assign m_tuser = {res.hold_expired, res.lost_sync, res.synced, res.sync_kind,
	                  res.voice_valid};
	assign m_tlast = res.frame_done;

endmodule

`default_nettype wire

/* tb/sv/fsk4_slicer_sync_voice_framer_test.sv */
// Self-checking testbench for the 4FSK slicer, sync detector and voice burst framer.
`default_nettype none

module fsk4_slicer_sync_voice_framer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fsvf_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		fsvf_cmd_t   cmd;
		logic [15:0] sample;
	} cmd_beat_t;

	typedef enum logic [1:0] {VP_FIRST, VP_MID_A, VP_MID_B, VP_LAST} vphase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	fsk4_slicer_sync_voice_framer u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// register shadow
	logic [14:0] lvl_max    = LEVEL_MAX_RST;
	logic [47:0] data_word  = DATA_SYNC_RST;
	logic [47:0] voice_word = VOICE_SYNC_RST;

	// framer state
	logic [47:0] hist       = '0;
	logic [7:0]  skip_cnt   = '0;
	vphase_t     phase      = VP_FIRST;
	logic [5:0]  pos        = '0;
	logic [2:0]  frames_cnt = '0;
	logic [10:0] hold_cnt   = '0;
	logic [5:0]  tick_cnt   = '0;

	cmd_beat_t    pend_q[$];
	fsvf_result_t results_due[$];
	cmd_beat_t    next_beat;

	int  queued = 0, taken = 0, checked = 0, mismatches = 0, cycles = 0;
	int  n_stored = 0, n_frames = 0, n_vsync = 0, n_dsync = 0, n_lost = 0, n_expired = 0;
	bit  in_taken = 1'b0, idle_on = 1'b0, long_hold_req = 1'b0, long_hold_used = 1'b0;
	int  src_gap = 0, sink_gap = 0, sink_block_left = 0;

	function automatic void load_voice_start();
		skip_cnt   = VOICE_SYNC_SKIP;
		phase      = VP_LAST;
		pos        = '0;
		frames_cnt = FRAMES_LOAD;
		hold_cnt   = SYNC_HOLD_LOAD;
		tick_cnt   = TICK_HOLD_SYNC;
	endfunction

	function automatic fsvf_result_t framer_step(fsvf_cmd_t cmd, logic [15:0] smp);
		fsvf_result_t r;
		fsvf_dibit_t  d;
		int           s, thr;
		r = '0;
		case (cmd)
			CMD_SAMPLE: begin
				s = int'($signed(smp)) + int'(SAMPLE_OFFSET);
				thr = int'(lvl_max >> 1);
				if (s > thr) d = DIBIT_P3;
				else if (s > 0) d = DIBIT_P1;
				else if (s < -thr) d = DIBIT_M3;
				else d = DIBIT_M1;
				r.dibit = d;
				hist = {hist[45:0], d};
				if (skip_cnt != 0) begin
					skip_cnt = skip_cnt - 1'b1;
				end else if (hold_cnt != 0) begin
					r.voice_valid = 1'b1;
					r.voice_index = pos;
					pos = pos + 1'b1;
					if (phase == VP_FIRST && pos == FRAME_LEN) begin
						phase = VP_MID_A;
						pos = '0;
						r.frame_done = 1'b1;
					end else if (phase == VP_MID_A && pos == HALF_FRAME) begin
						phase = VP_MID_B;
						skip_cnt = SYNC_SKIP;
					end else if (phase == VP_MID_B && pos == FRAME_LEN) begin
						phase = VP_LAST;
						pos = '0;
						r.frame_done = 1'b1;
					end else if (phase == VP_LAST && pos == FRAME_LEN) begin
						r.frame_done = 1'b1;
						pos = '0;
						skip_cnt = CACH_SLOT_SKIP;
						phase = VP_FIRST;
						if (frames_cnt != 0) frames_cnt = frames_cnt - 1'b1;
					end
				end
				if (hist == data_word) begin
					r.sync_kind = SYNC_DATA;
					if (hold_cnt == 0) skip_cnt = DATA_SYNC_SKIP;
				end else if (hist == voice_word) begin
					r.sync_kind = SYNC_VOICE;
					if (frames_cnt == 0 && hold_cnt == SYNC_CONT_AT) begin
						hold_cnt   = SYNC_HOLD_LOAD;
						tick_cnt   = TICK_HOLD_SYNC;
						frames_cnt = FRAMES_LOAD;
					end else begin
						load_voice_start();
					end
				end
				if (hold_cnt != 0) begin
					hold_cnt = hold_cnt - 1'b1;
					if (hold_cnt == 0) begin
						r.lost_sync = 1'b1;
						tick_cnt = TICK_HOLD_LOST;
						phase = VP_FIRST;
					end
				end
			end
			CMD_TICK: begin
				if (tick_cnt != 0) begin
					tick_cnt = tick_cnt - 1'b1;
					if (tick_cnt == 0) r.hold_expired = 1'b1;
				end
			end
			CMD_VOICE_RST: begin
				phase = VP_FIRST;
				hold_cnt = '0;
				frames_cnt = '0;
			end
			default: begin
				hold_cnt = '0;
				phase = VP_FIRST;
			end
		endcase
		r.synced = (hold_cnt != 0);
		return r;
	endfunction

	// sample that slices to the given dibit under the current level
	function automatic logic [15:0] sample_for(fsvf_dibit_t d);
		int thr, lo, hi, v;
		thr = int'(lvl_max >> 1);
		case (d)
			DIBIT_P3: begin lo = thr - 255; hi = 32767; end
			DIBIT_P1: begin lo = -255; hi = thr - 256; end
			DIBIT_M1: begin lo = -thr - 256; hi = -256; end
			default:  begin lo = -32768; hi = -thr - 257; end
		endcase
		// +1 has no range at a zero threshold
		if (hi < lo) begin
			lo = -thr - 256;
			hi = -256;
		end
		case ($urandom_range(0, 7))
			0: v = lo;
			1: v = hi;
			default: v = lo + int'($urandom_range(0, hi - lo));
		endcase
		return v[15:0];
	endfunction

	task automatic push_beat(fsvf_cmd_t c, logic [15:0] smp);
		cmd_beat_t b;
		b.cmd = c;
		b.sample = smp;
		pend_q.push_back(b);
		queued++;
	endtask

	task automatic push_word(logic [47:0] w);
		for (int k = 0; k < 24; k++)
			push_beat(CMD_SAMPLE, sample_for(fsvf_dibit_t'(w[47 - 2*k -: 2])));
	endtask

	task automatic push_payload(int n, int noise_pct);
		repeat (n) begin
			if ($urandom_range(0, 99) < noise_pct)
				push_beat(fsvf_cmd_t'($urandom_range(1, 3)), 16'($urandom));
			else if ($urandom_range(0, 1) == 0)
				push_beat(CMD_SAMPLE, 16'($urandom));
			else
				push_beat(CMD_SAMPLE, sample_for(fsvf_dibit_t'($urandom_range(0, 3))));
		end
	endtask

	task automatic push_sequence();
		logic [47:0] w;
		int          k;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				push_word(voice_word);
				push_payload($urandom_range(0, 300), 2);
			end
			3: begin
				push_word(data_word);
				push_payload($urandom_range(0, 160), 2);
			end
			4: begin
				push_word(voice_word);
				push_payload($urandom_range(0, 120), 0);
				push_beat(fsvf_cmd_t'($urandom_range(2, 3)), 16'($urandom));
				push_payload($urandom_range(0, 40), 0);
			end
			5: repeat ($urandom_range(20, 45)) push_beat(CMD_TICK, 16'($urandom));
			6: begin
				w = voice_word;
				k = $urandom_range(0, 23);
				w[2*k +: 2] = w[2*k +: 2] ^ 2'($urandom_range(1, 3));
				push_word(w);
				push_payload($urandom_range(0, 60), 5);
			end
			7: repeat ($urandom_range(10, 60))
				push_beat(fsvf_cmd_t'($urandom_range(0, 3)), 16'($urandom));
			8: begin
				// burst-spaced resync
				push_word(voice_word);
				push_payload(264, 0);
				push_word(voice_word);
				push_payload($urandom_range(0, 100), 2);
			end
			default: begin
				push_word(voice_word);
				push_payload($urandom_range(0, 30), 0);
				push_word(data_word);
				push_payload($urandom_range(0, 60), 2);
			end
		endcase
	endtask

	task automatic run_random(int n, bit vary_idle);
		int base;
		base = queued;
		while (queued - base < n) begin
			while (pend_q.size() > 8) @(negedge clk);
			if (vary_idle) idle_on = ($urandom_range(0, 3) != 0);
			push_sequence();
		end
	endtask

	task automatic drain();
		while (checked != queued) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic [4:0] addr, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [14:0] lvl, logic [47:0] dw, logic [47:0] vw);
		drain();
		apb_write(ADDR_LEVEL_MAX, 64'(lvl));
		apb_write(ADDR_DATA_SYNC, 64'(dw));
		apb_write(ADDR_VOICE_SYNC, 64'(vw));
		lvl_max = lvl;
		data_word = dw;
		voice_word = vw;
	endtask

	task automatic check_field(string name, logic [5:0] want, logic [5:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %0d, got %0d", checked, name, want, got);
		end
	endtask

	// command beats
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pend_q.size() != 0) begin
				next_beat = pend_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_beat.cmd;
				s_tdata <= next_beat.sample;
				if (idle_on && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 14);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side ready
	always @(negedge clk) begin
		if (long_hold_req && !long_hold_used) begin
			long_hold_used = 1'b1;
			sink_block_left = 300;
		end
		if (sink_block_left > 0) begin
			sink_block_left--;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 14);
		end
	end

	// predict on input beats, check output beats
	always @(posedge clk) begin
		fsvf_result_t want;
		in_taken = s_tvalid && s_tready;
		if (in_taken) begin
			results_due.push_back(framer_step(fsvf_cmd_t'(s_tuser), s_tdata));
			taken++;
		end
		if (m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result beat with nothing outstanding");
			end else begin
				want = results_due.pop_front();
				check_field("dibit", 6'(want.dibit), 6'(m_tdata[1:0]));
				check_field("voice_valid", 6'(want.voice_valid), 6'(m_tuser[0]));
				check_field("voice_index", want.voice_index, m_tdata[7:2]);
				check_field("frame_done", 6'(want.frame_done), 6'(m_tlast));
				check_field("sync_kind", 6'(want.sync_kind), 6'(m_tuser[2:1]));
				check_field("synced", 6'(want.synced), 6'(m_tuser[3]));
				check_field("lost_sync", 6'(want.lost_sync), 6'(m_tuser[4]));
				check_field("hold_expired", 6'(want.hold_expired), 6'(m_tuser[5]));
				n_stored += want.voice_valid;
				n_frames += want.frame_done;
				n_vsync += (want.sync_kind == SYNC_VOICE);
				n_dsync += (want.sync_kind == SYNC_DATA);
				n_lost += want.lost_sync;
				n_expired += want.hold_expired;
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("fsk4_slicer_sync_voice_framer verification failed");
			$finish;
		end
	end

	initial begin
		logic [63:0] w;
		logic [63:0] w2;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// slicer edges around the default threshold and every command
		push_beat(CMD_SAMPLE, 16'h8000);
		push_beat(CMD_SAMPLE, 16'h7fff);
		push_beat(CMD_SAMPLE, 16'd1792);
		push_beat(CMD_SAMPLE, 16'd1793);
		push_beat(CMD_SAMPLE, -16'sd255);
		push_beat(CMD_SAMPLE, -16'sd256);
		push_beat(CMD_SAMPLE, -16'sd2304);
		push_beat(CMD_SAMPLE, -16'sd2305);
		push_beat(CMD_SAMPLE, 16'd0);
		push_beat(CMD_SAMPLE, 16'hffff);
		push_beat(CMD_TICK, 16'hffff);
		push_beat(CMD_VOICE_RST, 16'h5555);
		push_beat(CMD_LOST_CARR, 16'haaaa);
		push_beat(CMD_TICK, 16'h0000);
		push_word(voice_word);
		push_beat(CMD_LOST_CARR, 16'h0);

		idle_on = 1'b1;
		run_random(40, 1'b1);
		drain();
		long_hold_req = 1'b1;
		run_random(40, 1'b1);

		set_config(15'd0, 48'd0, 48'hffff_ffff_ffff);
		run_random(30, 1'b1);

		w = {$urandom, $urandom};
		set_config(15'h7fff, w[47:0], w[47:0]);
		run_random(30, 1'b1);

		// full six-frame superframe, continuation at the hold point, then tick expiry
		idle_on = 1'b0;
		w = {$urandom, $urandom};
		w2 = {$urandom, $urandom};
		set_config(15'($urandom_range(2, 32767)), w[47:0], w2[47:0]);
		push_word(voice_word);
		repeat (1690) push_beat(CMD_SAMPLE, 16'($urandom));
		push_word(voice_word);
		repeat (45) push_beat(CMD_TICK, 16'($urandom));

		drain();
		repeat (20) @(posedge clk);
		if (results_due.size() != 0) begin
			mismatches++;
			$display("%0d results never arrived", results_due.size());
		end
		$display("%0d command beats, %0d results: %0d voice dibits stored, %0d frames closed",
			taken, checked, n_stored, n_frames);
		$display("%0d voice and %0d data syncs, %0d sync losses, %0d hold expiries, %s",
			n_vsync, n_dsync, n_lost, n_expired, "over several register settings");
		if (mismatches == 0) begin
			$display("fsk4_slicer_sync_voice_framer verification clean");
		end else begin
			$display("fsk4_slicer_sync_voice_framer verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
